/* hdl/touch_key_debounce_event_defines.svh */
// ----------------------------------------------------------------------------
// Touch key debounce assertion macros
// Shared property macros for the checker of the touch key event block.
// ----------------------------------------------------------------------------
`ifndef TOUCH_KEY_DEBOUNCE_EVENT_DEFINES_SVH
`define TOUCH_KEY_DEBOUNCE_EVENT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TKDE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("touch key check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TKDE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("touch key check failed");

`endif

/* hdl/tkde_pkg.sv */
// ----------------------------------------------------------------------------
// Touch key debounce package
// Types, codes and a helper function shared by the touch key event block.
// ----------------------------------------------------------------------------
package tkde_pkg;

   localparam int DeltaWidth  = 16;
   localparam int CountWidth  = 8;
   localparam int KeyCount    = 4;
   localparam int EventWidth  = 3;
   localparam int IndexWidth  = 2;

   localparam logic [DeltaWidth-1:0] DeltaThresholdReset = 16'd60;
   localparam logic [CountWidth-1:0] DebounceCountReset  = 8'd2;
   localparam logic [CountWidth-1:0] HoldCountReset      = 8'd4;
   localparam logic [DeltaWidth-1:0] WetThresholdReset   = 16'd1300;
   localparam logic [CountWidth-1:0] HoldCounterMax      = 8'd255;

   localparam logic [KeyCount-1:0] KeyUp   = 4'b0001;
   localparam logic [KeyCount-1:0] KeyDown = 4'b0010;
   localparam logic [KeyCount-1:0] KeyOk   = 4'b0100;
   localparam logic [KeyCount-1:0] KeyBack = 4'b1000;
   localparam logic [KeyCount-1:0] KeyNone = 4'b0000;

   typedef enum logic [EventWidth-1:0] {
      EV_NONE     = 3'd0,
      EV_TAP_UP   = 3'd1,
      EV_TAP_DOWN = 3'd2,
      EV_TAP_OK   = 3'd3,
      EV_TAP_BACK = 3'd4,
      EV_COMBO    = 3'd5,
      EV_HOLD     = 3'd6
   } event_type;

   typedef enum logic [IndexWidth-1:0] {
      CSR_DELTA_THRESHOLD = 2'd0,
      CSR_DEBOUNCE_COUNT  = 2'd1,
      CSR_HOLD_COUNT      = 2'd2,
      CSR_WET_THRESHOLD   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DeltaWidth-1:0] delta_threshold;
      logic [CountWidth-1:0] debounce_count;
      logic [CountWidth-1:0] hold_count;
      logic [DeltaWidth-1:0] wet_threshold;
   } cfg_type;

   typedef struct packed {
      logic                wet;
      logic [KeyCount-1:0] raw_keys;
   } sense_type;

   function automatic event_type release_code(input logic [KeyCount-1:0] keys);
      event_type code;
      case (keys)
         KeyUp:          code = EV_TAP_UP;
         KeyDown:        code = EV_TAP_DOWN;
         KeyOk:          code = EV_TAP_OK;
         KeyBack:        code = EV_TAP_BACK;
         KeyUp | KeyOk:  code = EV_COMBO;
         default:        code = EV_NONE;
      endcase
      return code;
   endfunction

endpackage

/* hdl/tkde_csr.sv */
// ----------------------------------------------------------------------------
// Touch key configuration registers
// Holds the thresholds and counts written through the configuration port.
// ----------------------------------------------------------------------------
module tkde_csr
   import tkde_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [DeltaWidth-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_DELTA_THRESHOLD: cfg_in.delta_threshold = csr_data;
            CSR_DEBOUNCE_COUNT:  cfg_in.debounce_count  = csr_data[CountWidth-1:0];
            CSR_HOLD_COUNT:      cfg_in.hold_count      = csr_data[CountWidth-1:0];
            CSR_WET_THRESHOLD:   cfg_in.wet_threshold   = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delta_threshold <= DeltaThresholdReset;
         cfg_ff.debounce_count  <= DebounceCountReset;
         cfg_ff.hold_count      <= HoldCountReset;
         cfg_ff.wet_threshold   <= WetThresholdReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/tkde_sense.sv */
// ----------------------------------------------------------------------------
// Touch key sense stage
// Registers each request as a raw key mask and a wet flag.
// ----------------------------------------------------------------------------
module tkde_sense
   import tkde_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [DeltaWidth-1:0] req_delta_up,
   input  logic [DeltaWidth-1:0] req_delta_down,
   input  logic [DeltaWidth-1:0] req_delta_ok,
   input  logic [DeltaWidth-1:0] req_delta_back,
   input  logic [DeltaWidth-1:0] req_shield_level,
   output logic                  sense_valid,
   input  logic                  sense_ready,
   output sense_type             sense
);

   logic      valid_ff;
   logic      valid_in;
   sense_type sense_ff;
   sense_type sense_in;
   logic      take;

   assign req_ready   = !valid_ff || sense_ready;
   assign take        = req_valid && req_ready;
   assign sense_valid = valid_ff;
   assign sense       = sense_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (sense_ready) begin
         valid_in = 1'b0;
      end
      sense_in.wet      = req_shield_level >= cfg.wet_threshold;
      sense_in.raw_keys = {req_delta_back >= cfg.delta_threshold,
                           req_delta_ok   >= cfg.delta_threshold,
                           req_delta_down >= cfg.delta_threshold,
                           req_delta_up   >= cfg.delta_threshold};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sense_ff <= sense_in;
      end
   end

endmodule

/* hdl/tkde_track.sv */
// ----------------------------------------------------------------------------
// Touch key tracker
// Debounces the raw mask, raises tap and hold events and registers results.
// ----------------------------------------------------------------------------
module tkde_track
   import tkde_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  sense_valid,
   output logic                  sense_ready,
   input  sense_type             sense,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [EventWidth-1:0] rsp_event_code,
   output logic                  rsp_moisture_fault,
   output logic [KeyCount-1:0]   rsp_active_keys,
   output logic                  rsp_adapt_enable
);

   logic [KeyCount-1:0]   stable_ff, stable_in;
   logic [KeyCount-1:0]   cand_ff, cand_in;
   logic [CountWidth-1:0] deb_cnt_ff, deb_cnt_in;
   logic [CountWidth-1:0] hold_cnt_ff, hold_cnt_in;
   logic                  hold_sent_ff, hold_sent_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   event_type             event_ff, event_in;
   logic                  fault_ff;
   logic                  adapt_ff, adapt_in;
   logic                  step;

   assign sense_ready        = !rsp_valid_ff || rsp_ready;
   assign step               = sense_valid && sense_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_code     = event_ff;
   assign rsp_moisture_fault = fault_ff;
   assign rsp_active_keys    = stable_ff;
   assign rsp_adapt_enable   = adapt_ff;

   always_comb begin
      stable_in    = stable_ff;
      cand_in      = cand_ff;
      deb_cnt_in   = deb_cnt_ff;
      hold_cnt_in  = hold_cnt_ff;
      hold_sent_in = hold_sent_ff;
      event_in     = EV_NONE;
      adapt_in     = !sense.wet && (stable_ff == KeyNone);

      if (sense.wet) begin
         stable_in    = KeyNone;
         cand_in      = KeyNone;
         deb_cnt_in   = '0;
         hold_cnt_in  = '0;
         hold_sent_in = 1'b0;
      end else begin
         if (sense.raw_keys == cand_ff) begin
            if (deb_cnt_ff < cfg.debounce_count) begin
               deb_cnt_in = deb_cnt_ff + 1'b1;
            end
         end else begin
            cand_in    = sense.raw_keys;
            deb_cnt_in = CountWidth'(1);
         end

         if (deb_cnt_in >= cfg.debounce_count && stable_ff != cand_in) begin
            if (stable_ff != KeyNone && cand_in == KeyNone && !hold_sent_ff) begin
               event_in = release_code(stable_ff);
            end
            stable_in    = cand_in;
            hold_cnt_in  = '0;
            hold_sent_in = 1'b0;
         end

         if (stable_in != KeyNone) begin
            if (hold_cnt_in < HoldCounterMax) begin
               hold_cnt_in = hold_cnt_in + 1'b1;
            end
            if (!hold_sent_in && stable_in == KeyBack && hold_cnt_in >= cfg.hold_count) begin
               event_in     = EV_HOLD;
               hold_sent_in = 1'b1;
            end
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff    <= KeyNone;
         cand_ff      <= KeyNone;
         deb_cnt_ff   <= '0;
         hold_cnt_ff  <= '0;
         hold_sent_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            stable_ff    <= stable_in;
            cand_ff      <= cand_in;
            deb_cnt_ff   <= deb_cnt_in;
            hold_cnt_ff  <= hold_cnt_in;
            hold_sent_ff <= hold_sent_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         event_ff <= event_in;
         fault_ff <= sense.wet;
         adapt_ff <= adapt_in;
      end
   end

endmodule

/* hdl/touch_key_debounce_event.sv */
// ----------------------------------------------------------------------------
// Touch key debounce and event block
// Sense, then result register; one request per cycle unless results stall.
// The sense register and the result register bound each cycle of work.
// Synchronous reset restores the register defaults and clears all key state.
// ----------------------------------------------------------------------------
module touch_key_debounce_event
   import tkde_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [DeltaWidth-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [DeltaWidth-1:0] req_delta_up,
   input  logic [DeltaWidth-1:0] req_delta_down,
   input  logic [DeltaWidth-1:0] req_delta_ok,
   input  logic [DeltaWidth-1:0] req_delta_back,
   input  logic [DeltaWidth-1:0] req_shield_level,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [EventWidth-1:0] rsp_event_code,
   output logic                  rsp_moisture_fault,
   output logic [KeyCount-1:0]   rsp_active_keys,
   output logic                  rsp_adapt_enable
);

   cfg_type   cfg;
   sense_type sense;
   logic      sense_valid;
   logic      sense_ready;

   tkde_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tkde_sense u_sense (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_delta_up     (req_delta_up),
      .req_delta_down   (req_delta_down),
      .req_delta_ok     (req_delta_ok),
      .req_delta_back   (req_delta_back),
      .req_shield_level (req_shield_level),
      .sense_valid      (sense_valid),
      .sense_ready      (sense_ready),
      .sense            (sense)
   );

   tkde_track u_track (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .sense_valid        (sense_valid),
      .sense_ready        (sense_ready),
      .sense              (sense),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_code     (rsp_event_code),
      .rsp_moisture_fault (rsp_moisture_fault),
      .rsp_active_keys    (rsp_active_keys),
      .rsp_adapt_enable   (rsp_adapt_enable)
   );

endmodule

/* hdl/tkde_checker.sv */
// ----------------------------------------------------------------------------
// Touch key event checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "touch_key_debounce_event_defines.svh"

module tkde_checker
   import tkde_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [EventWidth-1:0] rsp_event_code,
   input logic                  rsp_moisture_fault,
   input logic [KeyCount-1:0]   rsp_active_keys,
   input logic                  rsp_adapt_enable
);

   // A wet pad reports no event, no keys and no baseline adaptation.
   `TKDE_ASSERT_NOW(a_wet_quiet, clock, reset, rsp_valid && rsp_moisture_fault, rsp_event_code == EV_NONE && rsp_active_keys == KeyNone && !rsp_adapt_enable)

   // A tap or combo only fires once the stable mask has fallen to no keys.
   `TKDE_ASSERT_NOW(a_tap_released, clock, reset, rsp_valid && rsp_event_code != EV_NONE && rsp_event_code != EV_HOLD, rsp_active_keys == KeyNone)

   // A hold only fires while back alone is held.
   `TKDE_ASSERT_NOW(a_hold_back, clock, reset, rsp_valid && rsp_event_code == EV_HOLD, rsp_active_keys == KeyBack)

   // A stalled result keeps its event code.
   `TKDE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_code))

endmodule

bind touch_key_debounce_event tkde_checker u_tkde_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_event_code     (rsp_event_code),
   .rsp_moisture_fault (rsp_moisture_fault),
   .rsp_active_keys    (rsp_active_keys),
   .rsp_adapt_enable   (rsp_adapt_enable)
);
